@@ design/awvn_pkg.sv @@
package awvn_pkg;

  localparam int MaxVertices = 1024;
  localparam int IdxBits = $clog2(MaxVertices);
  localparam int CoordBits = 24;
  localparam int AccBits = 64;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic [IdxBits-1:0] vi;
    logic [CoordBits-1:0] px;
    logic [CoordBits-1:0] py;
    logic [CoordBits-1:0] pz;
    logic [IdxBits-1:0] ca;
    logic [IdxBits-1:0] cb;
    logic [IdxBits-1:0] cc;
  } op_t;

  localparam logic signed [AccBits-1:0] AccMax = {1'b0, {(AccBits-1){1'b1}}};
  localparam logic signed [AccBits-1:0] AccMin = {1'b1, {(AccBits-1){1'b0}}};

  function automatic logic signed [AccBits-1:0] sat_add(
      input logic signed [AccBits-1:0] a, input logic signed [AccBits-1:0] b);
    logic signed [AccBits:0] s;
    s = {a[AccBits-1], a} + {b[AccBits-1], b};
    if (s[AccBits] != s[AccBits-1]) return s[AccBits] ? AccMin : AccMax;
    return s[AccBits-1:0];
  endfunction

  function automatic logic signed [AccBits-1:0] sat_sub(
      input logic signed [AccBits-1:0] a, input logic signed [AccBits-1:0] b);
    logic signed [AccBits:0] s;
    s = {a[AccBits-1], a} - {b[AccBits-1], b};
    if (s[AccBits] != s[AccBits-1]) return s[AccBits] ? AccMin : AccMax;
    return s[AccBits-1:0];
  endfunction

endpackage

@@ design/area_weighted_vertex_normals.sv @@
// Area-weighted smooth vertex normals.
// Input queue: drive cmd and its fields with push; a transfer happens when
// push is high and full is low. Load stores a Q8.16 position and clears the
// vertex accumulator, triangle adds the edge cross product to its three
// corners, read returns the normalized accumulator. Unused commands vanish.
// Result queue: while empty is low a read result is on the ports; it is
// transferred when pop is high. Only read commands give a result.
// A two-entry queue separates the accepting front from the engine, so
// items are taken while the engine works or a result waits to be popped.
// A load is written as the queue hands it over; a triangle runs three position reads,
// edge, multiply and cross stages, then three accumulator read-modify-writes.
// A read runs a scale search that shifts one bit per cycle, a square root and
// three 47-bit divisions. An all-zero accumulator skips all three steps
// and returns the up vector.
// When a result is not popped, the engine stops at the next read and the
// queue fills, raising full. Reset empties both queues; memory contents are
// undefined until loaded.
module area_weighted_vertex_normals (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [9:0]  vertex_index,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic [9:0]  corner_a,
  input  logic [9:0]  corner_b,
  input  logic [9:0]  corner_c,
  output logic        empty,
  input  logic        pop,
  output logic [9:0]  out_vertex,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic        was_degenerate
);
  import awvn_pkg::*;

  op_t op_in, q_op;
  logic q_valid, q_take, res_valid;

  assign op_in = '{cmd: cmd_t'(cmd), vi: vertex_index, px: pos_x, py: pos_y, pz: pos_z,
                   ca: corner_a, cb: corner_b, cc: corner_c};
  assign empty = !res_valid;

  awvn_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .op_in(op_in),
    .q_valid(q_valid), .q_op(q_op), .q_take(q_take)
  );

  awvn_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_op(q_op), .q_take(q_take),
    .res_valid(res_valid), .res_vertex(out_vertex), .res_x(normal_x),
    .res_y(normal_y), .res_z(normal_z), .res_degen(was_degenerate),
    .res_take(pop && res_valid)
  );

  a_take_needs_valid: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid) else $error("engine took from an empty queue");

  a_degen_up: assert property (@(posedge clk) disable iff (rst)
    (!empty && was_degenerate) |-> (normal_y == 16'sd16384 && normal_x == 16'sd0))
    else $error("degenerate result is not the up vector");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    ($past(!empty) && $past(!pop) && !$past(rst)) |-> (!empty && $stable(out_vertex)))
    else $error("stalled result changed");

endmodule

@@ design/awvn_front.sv @@
module awvn_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  awvn_pkg::op_t  op_in,
  output logic           q_valid,
  output awvn_pkg::op_t  q_op,
  input  logic           q_take
);
  import awvn_pkg::*;

  op_t slots [QDepth];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic do_push, keep;

  // Commands that do nothing are dropped here and never reach the engine.
  assign keep = (op_in.cmd != CMD_NONE);
  assign full = (count == 2'(QDepth));
  assign do_push = push && !full && keep;
  assign q_valid = (count != 2'd0);
  assign q_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= op_in;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (q_take) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(q_take);
    end
  end

endmodule

@@ design/awvn_norm.sv @@
module awvn_norm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [awvn_pkg::AccBits-1:0] vx,
  input  logic signed [awvn_pkg::AccBits-1:0] vy,
  input  logic signed [awvn_pkg::AccBits-1:0] vz,
  output logic                           done,
  output logic signed [15:0]             nx,
  output logic signed [15:0]             ny,
  output logic signed [15:0]             nz,
  output logic                           degen
);
  import awvn_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_SQ, S_SQRT, S_DIV, S_DONE} state_t;

  state_t state;
  logic [AccBits-1:0] a [3];
  logic [2:0] sgn;
  logic [AccBits-1:0] m, l2, res, bitv;
  logic [1:0] k;
  logic [5:0] cnt;
  logic [46:0] dnum, dq;
  logic [47:0] drem;
  logic [31:0] r;
  logic [15:0] q [3];
  logic [47:0] trial;
  logic [59:0] sq;

  assign done = (state == S_DONE);
  assign nx = sgn[0] ? -q[0] : q[0];
  assign ny = sgn[1] ? -q[1] : q[1];
  assign nz = sgn[2] ? -q[2] : q[2];
  assign trial = {drem[46:0], dnum[46]};
  // Scaled magnitudes stay below 2^30, so the square fits in 60 bits.
  assign sq = a[k][29:0] * a[k][29:0];

  function automatic logic [AccBits-1:0] mag(input logic signed [AccBits-1:0] x);
    return x[AccBits-1] ? AccBits'(-x) : AccBits'(x);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      degen <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (start) begin
          a[0] <= mag(vx);
          a[1] <= mag(vy);
          a[2] <= mag(vz);
          sgn <= {vz[AccBits-1], vy[AccBits-1], vx[AccBits-1]};
          m <= (mag(vx) > mag(vy)) ? ((mag(vx) > mag(vz)) ? mag(vx) : mag(vz))
                                   : ((mag(vy) > mag(vz)) ? mag(vy) : mag(vz));
          if (vx == '0 && vy == '0 && vz == '0) begin
            q[0] <= 16'd0;
            q[1] <= 16'd16384;
            q[2] <= 16'd0;
            degen <= 1'b1;
            state <= S_DONE;
          end else begin
            degen <= 1'b0;
            state <= S_SHIFT;
          end
        end
        // One bit of shift per cycle until the largest magnitude is in [2^29, 2^30).
        S_SHIFT: begin
          if (m >= (64'd1 << 30)) begin
            m <= m >> 1;
            for (int i = 0; i < 3; i++) a[i] <= a[i] >> 1;
          end else if (m < (64'd1 << 29)) begin
            m <= m << 1;
            for (int i = 0; i < 3; i++) a[i] <= a[i] << 1;
          end else begin
            l2 <= '0;
            k <= 2'd0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          l2 <= l2 + AccBits'(sq);
          if (k == 2'd2) begin
            bitv <= 64'd1 << 62;
            res <= '0;
            state <= S_SQRT;
          end else k <= k + 2'd1;
        end
        S_SQRT: begin
          if (bitv == '0) begin
            r <= res[31:0];
            k <= 2'd0;
            cnt <= 6'd0;
            dnum <= {a[0][30:0], 14'd0} + 47'(res[31:1]);
            drem <= '0;
            state <= S_DIV;
          end else if (l2 >= res + bitv) begin
            l2 <= l2 - (res + bitv);
            res <= (res >> 1) + bitv;
            bitv <= bitv >> 2;
          end else begin
            res <= res >> 1;
            bitv <= bitv >> 2;
          end
        end
        // Restoring division, one quotient bit per cycle.
        S_DIV: begin
          if (trial >= {16'd0, r}) dq <= {dq[45:0], 1'b1};
          else dq <= {dq[45:0], 1'b0};
          if (cnt == 6'd46) begin
            q[k] <= 16'({dq[45:0], (trial >= {16'd0, r})});
            cnt <= 6'd0;
            drem <= '0;
            if (k == 2'd2) state <= S_DONE;
            else begin
              dnum <= {a[k+2'd1][30:0], 14'd0} + 47'(r[31:1]);
              k <= k + 2'd1;
            end
          end else begin
            cnt <= cnt + 6'd1;
            dnum <= dnum << 1;
            drem <= (trial >= {16'd0, r}) ? trial - {16'd0, r} : trial;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/awvn_back.sv @@
module awvn_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  awvn_pkg::op_t  q_op,
  output logic           q_take,
  output logic           res_valid,
  output logic [awvn_pkg::IdxBits-1:0] res_vertex,
  output logic signed [15:0] res_x,
  output logic signed [15:0] res_y,
  output logic signed [15:0] res_z,
  output logic           res_degen,
  input  logic           res_take
);
  import awvn_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_RDA, B_RDB, B_RDC, B_WAITC, B_MUL, B_CROSS,
    B_ACC_RD, B_ACC_WAIT, B_ACC_WR, B_RD_ACC, B_RD_WAIT, B_NORM
  } state_t;

  state_t state;
  op_t op;
  logic [3*CoordBits-1:0] pos_mem [MaxVertices];
  logic [AccBits-1:0] accx_mem [MaxVertices];
  logic [AccBits-1:0] accy_mem [MaxVertices];
  logic [AccBits-1:0] accz_mem [MaxVertices];
  logic [3*CoordBits-1:0] pos_rd;
  logic signed [AccBits-1:0] ax_rd, ay_rd, az_rd;
  logic [IdxBits-1:0] pos_addr, acc_addr;
  logic signed [CoordBits-1:0] pa [3];
  logic signed [CoordBits:0] e1 [3];
  logic signed [CoordBits:0] e2 [3];
  logic signed [2*CoordBits+1:0] p [6];
  logic signed [AccBits-1:0] n [3];
  logic [1:0] corner;
  logic pos_we, acc_we;
  logic [AccBits-1:0] wx, wy, wz;
  logic norm_start, norm_done, norm_degen;
  logic signed [15:0] nx, ny, nz;

  // Edge components are at most 25 bits, so neither the products nor their
  // difference reach the saturation limits; only the accumulator sums can.
  assign q_take = q_valid && (state == B_IDLE) &&
                  !(q_op.cmd == CMD_READ && res_valid);

  always_comb begin
    pos_addr = op.ca;
    case (state)
      B_RDA: pos_addr = op.ca;
      B_RDB: pos_addr = op.cb;
      B_RDC: pos_addr = op.cc;
      default: pos_addr = op.ca;
    endcase
    case (corner)
      2'd0: acc_addr = op.ca;
      2'd1: acc_addr = op.cb;
      default: acc_addr = op.cc;
    endcase
    if (state == B_RD_ACC) acc_addr = op.vi;
    pos_we = (state == B_IDLE) && q_take && (q_op.cmd == CMD_LOAD);
    acc_we = pos_we || (state == B_ACC_WR);
    wx = pos_we ? '0 : sat_add(ax_rd, n[0]);
    wy = pos_we ? '0 : sat_add(ay_rd, n[1]);
    wz = pos_we ? '0 : sat_add(az_rd, n[2]);
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[q_op.vi] <= {q_op.px, q_op.py, q_op.pz};
    else pos_rd <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      accx_mem[pos_we ? q_op.vi : acc_addr] <= wx;
      accy_mem[pos_we ? q_op.vi : acc_addr] <= wy;
      accz_mem[pos_we ? q_op.vi : acc_addr] <= wz;
    end else begin
      ax_rd <= accx_mem[acc_addr];
      ay_rd <= accy_mem[acc_addr];
      az_rd <= accz_mem[acc_addr];
    end
  end

  awvn_norm u_norm (
    .clk(clk), .rst(rst), .start(norm_start),
    .vx(ax_rd), .vy(ay_rd), .vz(az_rd),
    .done(norm_done),
    .nx(nx), .ny(ny), .nz(nz), .degen(norm_degen)
  );

  assign norm_start = (state == B_RD_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      res_valid <= 1'b0;
      corner <= 2'd0;
    end else begin
      if (res_take) res_valid <= 1'b0;
      case (state)
        B_IDLE: if (q_take) begin
          op <= q_op;
          corner <= 2'd0;
          case (q_op.cmd)
            CMD_TRI: state <= B_RDA;
            CMD_READ: state <= B_RD_ACC;
            default: state <= B_IDLE;
          endcase
        end
        B_RDA: state <= B_RDB;
        B_RDB: begin
          pa[0] <= pos_rd[3*CoordBits-1 -: CoordBits];
          pa[1] <= pos_rd[2*CoordBits-1 -: CoordBits];
          pa[2] <= pos_rd[CoordBits-1:0];
          state <= B_RDC;
        end
        B_RDC: begin
          e1[0] <= $signed(pos_rd[3*CoordBits-1 -: CoordBits]) - pa[0];
          e1[1] <= $signed(pos_rd[2*CoordBits-1 -: CoordBits]) - pa[1];
          e1[2] <= $signed(pos_rd[CoordBits-1:0]) - pa[2];
          state <= B_WAITC;
        end
        B_WAITC: begin
          e2[0] <= $signed(pos_rd[3*CoordBits-1 -: CoordBits]) - pa[0];
          e2[1] <= $signed(pos_rd[2*CoordBits-1 -: CoordBits]) - pa[1];
          e2[2] <= $signed(pos_rd[CoordBits-1:0]) - pa[2];
          state <= B_MUL;
        end
        B_MUL: begin
          p[0] <= e1[1] * e2[2];
          p[1] <= e1[2] * e2[1];
          p[2] <= e1[2] * e2[0];
          p[3] <= e1[0] * e2[2];
          p[4] <= e1[0] * e2[1];
          p[5] <= e1[1] * e2[0];
          state <= B_CROSS;
        end
        B_CROSS: begin
          n[0] <= sat_sub(AccBits'(p[0]), AccBits'(p[1]));
          n[1] <= sat_sub(AccBits'(p[2]), AccBits'(p[3]));
          n[2] <= sat_sub(AccBits'(p[4]), AccBits'(p[5]));
          state <= B_ACC_RD;
        end
        B_ACC_RD: state <= B_ACC_WAIT;
        B_ACC_WAIT: state <= B_ACC_WR;
        B_ACC_WR: begin
          if (corner == 2'd2) state <= B_IDLE;
          else begin
            corner <= corner + 2'd1;
            state <= B_ACC_RD;
          end
        end
        B_RD_ACC: state <= B_RD_WAIT;
        B_RD_WAIT: state <= B_NORM;
        B_NORM: if (norm_done) begin
          res_valid <= 1'b1;
          res_vertex <= op.vi;
          res_x <= nx;
          res_y <= ny;
          res_z <= nz;
          res_degen <= norm_degen;
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

@@ bench/area_weighted_vertex_normals_tb.sv @@
module area_weighted_vertex_normals_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import awvn_pkg::*;

  typedef struct {
    logic [9:0] vtx;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic degen;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] cmd = CMD_NONE;
  logic [9:0] vertex_index = '0;
  logic signed [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [9:0] corner_a = '0, corner_b = '0, corner_c = '0;
  logic full, empty, was_degenerate;
  logic [9:0] out_vertex;
  logic signed [15:0] normal_x, normal_y, normal_z;

  area_weighted_vertex_normals i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd),
    .vertex_index(vertex_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .empty(empty), .pop(pop), .out_vertex(out_vertex), .normal_x(normal_x),
    .normal_y(normal_y), .normal_z(normal_z), .was_degenerate(was_degenerate)
  );

  op_t pending_ops[$];
  normal_t expected_normals[$];
  longint vtx_pos[MaxVertices][3];
  longint vtx_acc[MaxVertices][3];
  int gen_loaded[$];
  bit is_loaded[MaxVertices];
  int errors = 0;
  int normals_checked = 0;
  int tris_sent = 0;
  int send_gap = 0, recv_gap = 0, recv_hold = 0;
  bit held_once = 0;
  bit calm;

  initial forever #5 clk = ~clk;

  function automatic longint acc_add(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? longint'(AccMin) : longint'(AccMax);
    return longint'(s[63:0]);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != '0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic normal_t unit_normal(int vi);
    normal_t n;
    logic [63:0] a[3], m, l2, r, q;
    longint s;
    m = '0;
    l2 = '0;
    n.vtx = vi[9:0];
    for (int i = 0; i < 3; i++) begin
      s = vtx_acc[vi][i];
      a[i] = s < 0 ? 64'(-s) : 64'(s);
      if (a[i] > m) m = a[i];
    end
    if (m == '0) begin
      n.nx = '0; n.ny = 16'sd16384; n.nz = '0; n.degen = 1'b1;
      return n;
    end
    // Scale so the largest magnitude lands in [2^29, 2^30).
    while (m >= (64'd1 << 30)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
    end
    for (int i = 0; i < 3; i++) l2 += a[i] * a[i];
    r = root_floor(l2);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << 14) + (r >> 1)) / r;
      if (vtx_acc[vi][i] < 0) q = -q;
      if (i == 0) n.nx = q[15:0];
      else if (i == 1) n.ny = q[15:0];
      else n.nz = q[15:0];
    end
    n.degen = 1'b0;
    return n;
  endfunction

  function automatic void apply_op(op_t op);
    longint e1[3], e2[3], cr[3];
    int c[3];
    case (op.cmd)
      CMD_LOAD: begin
        vtx_pos[op.vi][0] = longint'($signed(op.px));
        vtx_pos[op.vi][1] = longint'($signed(op.py));
        vtx_pos[op.vi][2] = longint'($signed(op.pz));
        for (int k = 0; k < 3; k++) vtx_acc[op.vi][k] = 0;
      end
      CMD_TRI: begin
        c[0] = int'(op.ca); c[1] = int'(op.cb); c[2] = int'(op.cc);
        for (int k = 0; k < 3; k++) begin
          e1[k] = vtx_pos[c[1]][k] - vtx_pos[c[0]][k];
          e2[k] = vtx_pos[c[2]][k] - vtx_pos[c[0]][k];
        end
        // Edges are 25 bits wide, so the products and differences are exact.
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++) vtx_acc[c[j]][k] = acc_add(vtx_acc[c[j]][k], cr[k]);
      end
      CMD_READ: expected_normals = {expected_normals, unit_normal(int'(op.vi))};
      default: ;
    endcase
  endfunction

  function automatic op_t noise_op();
    op_t op;
    op.cmd = CMD_NONE;
    op.vi = 10'($urandom); op.px = 24'($urandom); op.py = 24'($urandom);
    op.pz = 24'($urandom);
    op.ca = 10'($urandom); op.cb = 10'($urandom); op.cc = 10'($urandom);
    return op;
  endfunction

  function automatic void queue_op(op_t op);
    pending_ops = {pending_ops, op};
  endfunction

  task automatic add_load(int vi, int x, int y, int z);
    op_t op;
    op = noise_op();
    op.cmd = CMD_LOAD; op.vi = 10'(vi); op.px = 24'(x); op.py = 24'(y); op.pz = 24'(z);
    if (!is_loaded[vi]) gen_loaded = {gen_loaded, vi};
    is_loaded[vi] = 1;
    queue_op(op);
  endtask

  task automatic add_tri(int a, int b, int c);
    op_t op;
    op = noise_op();
    op.cmd = CMD_TRI; op.ca = 10'(a); op.cb = 10'(b); op.cc = 10'(c);
    tris_sent++;
    queue_op(op);
  endtask

  task automatic add_read(int vi);
    op_t op;
    op = noise_op();
    op.cmd = CMD_READ; op.vi = 10'(vi);
    queue_op(op);
  endtask

  function automatic int any_loaded();
    return gen_loaded[$urandom_range(0, gen_loaded.size() - 1)];
  endfunction

  initial begin
    int sel, a, b, sh;
    add_load(0, 0, 0, 0);
    add_load(1, 8388607, 0, 0);
    add_load(2, 0, 8388607, 0);
    add_load(1023, -8388608, -8388608, -8388608);
    add_read(0);
    add_tri(0, 1, 2);
    add_read(0);
    add_read(1);
    add_read(2);
    add_tri(0, 1, 1023);
    add_tri(1023, 2, 1);
    add_read(1023);
    // A repeated corner gives a zero cross product.
    add_tri(0, 0, 1);
    add_read(0);
    queue_op(noise_op());
    add_load(5, 65536, 0, 0);
    add_load(6, 0, 65536, -1);
    add_load(7, -1, -1, 65536);
    add_tri(5, 6, 7);
    add_tri(7, 6, 5);
    // Opposite windings cancel back to a zero accumulator.
    add_read(5);
    add_load(1, 100, -200, 300);
    add_read(1);
    add_read(7);
    repeat (380) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        sh = $urandom_range(0, 20);
        add_load($urandom_range(0, 1023), $signed(24'($urandom)) >>> sh,
                 $signed(24'($urandom)) >>> sh, $signed(24'($urandom)) >>> sh);
      end else if (sel < 60) begin
        a = any_loaded();
        b = any_loaded();
        if (sel < 24) add_tri(a, b, a);
        else add_tri(a, b, any_loaded());
      end else if (sel < 94) begin
        add_read(any_loaded());
      end else begin
        queue_op(noise_op());
      end
    end
  end

  assign calm = pending_ops.size() < 60;

  // Sender: the head of pending_ops stays on the ports until it transfers.
  always @(posedge clk) begin
    logic next_push;
    if (rst) begin
      push <= 1'b0;
    end else begin
      next_push = push;
      if (push && !full) begin
        apply_op(pending_ops.pop_front());
        next_push = 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 5);
      end
      if (!next_push) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_ops.size() > 0) begin
          next_push = 1'b1;
          cmd <= pending_ops[0].cmd;
          vertex_index <= pending_ops[0].vi;
          pos_x <= pending_ops[0].px;
          pos_y <= pending_ops[0].py;
          pos_z <= pending_ops[0].pz;
          corner_a <= pending_ops[0].ca;
          corner_b <= pending_ops[0].cb;
          corner_c <= pending_ops[0].cc;
        end
      end
      push <= next_push;
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    normal_t exp_n;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_normals.size() == 0) begin
          $display("%0t: unexpected result for vertex %0d", $time, out_vertex);
          errors++;
        end else begin
          exp_n = expected_normals.pop_front();
          normals_checked++;
          if (out_vertex !== exp_n.vtx) begin
            $display("%0t: out_vertex expected %0d actual %0d", $time, exp_n.vtx, out_vertex);
            errors++;
          end
          if (normal_x !== exp_n.nx) begin
            $display("%0t: normal_x expected %0d actual %0d", $time, exp_n.nx, normal_x);
            errors++;
          end
          if (normal_y !== exp_n.ny) begin
            $display("%0t: normal_y expected %0d actual %0d", $time, exp_n.ny, normal_y);
            errors++;
          end
          if (normal_z !== exp_n.nz) begin
            $display("%0t: normal_z expected %0d actual %0d", $time, exp_n.nz, normal_z);
            errors++;
          end
          if (was_degenerate !== exp_n.degen) begin
            $display("%0t: was_degenerate expected %0b actual %0b", $time, exp_n.degen,
                     was_degenerate);
            errors++;
          end
        end
        if (normals_checked == 8 && !held_once) begin
          held_once = 1;
          recv_hold = 600;
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 5);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_ops.size() > 0 || expected_normals.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (expected_normals.size() > 0) begin
      $display("%0t: %0d expected normals never arrived", $time, expected_normals.size());
      errors++;
    end
    $display("Checked %0d normals after %0d triangles, with a long result stall.",
             normals_checked, tris_sent);
    if (errors == 0) begin
      $display("area_weighted_vertex_normals: match");
    end else begin
      $display("area_weighted_vertex_normals: mismatch");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Timed out with %0d items unsent", pending_ops.size());
    $display("area_weighted_vertex_normals: mismatch");
    $finish;
  end
endmodule
